/* rtl/core/spt_pkg.sv */
// Shared constants, types and codes for the stride pattern tally block.
// Has no dependencies; every other file in rtl/core but spt_ram imports it.
package spt_pkg;

    localparam int NUM_POINTS      = 64;
    localparam int MAX_LOG2_STRIDE = 6;

    localparam int ADDR_W = 64;
    localparam int CNT_W  = 64;
    localparam int SIZE_W = 8;
    localparam int ID_W   = 6;
    localparam int SEL_W  = 4;
    localparam int CLS_W  = 4;
    localparam int PT_W   = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

    // Counter row layout: stride classes first, then backward, then total.
    // This matches the tally select codes, so a select indexes the row.
    localparam int NUM_CLASSES = MAX_LOG2_STRIDE + 3;
    localparam int NUM_CNT     = MAX_LOG2_STRIDE + 5;
    localparam int CNT_IW      = $clog2(NUM_CNT);

    localparam logic [CLS_W-1:0] CLS_ZERO  = CLS_W'(MAX_LOG2_STRIDE + 1);
    localparam logic [CLS_W-1:0] CLS_OTHER = CLS_W'(MAX_LOG2_STRIDE + 2);
    localparam logic [CLS_W-1:0] CLS_NONE  = CLS_W'(MAX_LOG2_STRIDE + 3);

    localparam int CNT_BACK  = MAX_LOG2_STRIDE + 3;
    localparam int CNT_TOTAL = MAX_LOG2_STRIDE + 4;

    localparam logic CMD_TRACK = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] bytes;
        logic              store;
    } meta_t;

    localparam int META_W = $bits(meta_t);

    typedef logic [NUM_CNT-1:0][CNT_W-1:0] counter_row_t;

    localparam int ROW_W = $bits(counter_row_t);

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             back;
    } class_t;

endpackage

/* rtl/core/spt_ram.sv */
// Generic single-clock RAM: one write port, one read port with a read
// enable and registered read data. No package dependency.
module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/spt_classify.sv */
// Stride classifier: distance between stored and new address against the
// stored access size shifted by 0..MAX_LOG2_STRIDE. Depends on spt_pkg.
module spt_classify (
    input  logic [spt_pkg::ADDR_W-1:0] old_addr,
    input  logic [spt_pkg::ADDR_W-1:0] next_addr,
    input  logic [spt_pkg::SIZE_W-1:0] size,
    output spt_pkg::class_t            result
);
    import spt_pkg::*;

    logic [ADDR_W-1:0] gap;
    logic              back;

    assign back = next_addr < old_addr;
    assign gap  = back ? (old_addr - next_addr) : (next_addr - old_addr);

    always_comb
    begin
        result.back = back;
        result.cls  = CLS_OTHER;
        // Search from the top so the smallest matching shift wins.
        for (int k = MAX_LOG2_STRIDE; k >= 0; k--)
        begin
            if (gap == (ADDR_W'(size) << k))
            begin
                result.cls = CLS_W'(k);
            end
        end
        if (next_addr == old_addr)
        begin
            result.cls = CLS_ZERO;
        end
    end

endmodule

/* rtl/core/stride_pattern_tally.sv */
// Stride pattern tally top level: slot sequencer, state memories, result
// register. Depends on spt_pkg, spt_ram and spt_classify.
//
// Per-call-point stride profiler. The accept cycle reads the slot's
// metadata and counter row from two synchronous memories, the next cycle
// classifies the stride, and the write step updates the counters, writes
// both rows back and loads the result register, holding while a stalled
// result still occupies it. No new item is taken until this
// read-classify-write sequence on the single memory port pair is done,
// but one is taken as soon as the sequencer is idle, even while the
// previous result still waits downstream. A track item on an unseen slot
// creates it (address, size and load/store flag stored, all counters
// written as zero); later track items class the distance as zero, 2^k
// words for k up to MAX_LOG2_STRIDE, or other, and bump that class, the
// total and, on a backward step, the backward count. A read item returns
// one counter of a slot. Counters wrap at 2^64. Slot valid bits live in
// flip-flops cleared by reset, so no clearing pass is needed.
module stride_pattern_tally (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic                       cmd,
    input  logic [spt_pkg::ID_W-1:0]   point_id,
    input  logic [spt_pkg::ADDR_W-1:0] address,
    input  logic [spt_pkg::SIZE_W-1:0] word_bytes,
    input  logic                       store_flag,
    input  logic [spt_pkg::SEL_W-1:0]  tally_select,
    // response channel
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic                       entry_valid,
    output logic                       first_access,
    output logic [spt_pkg::CLS_W-1:0]  stride_class,
    output logic                       went_backward,
    output logic [spt_pkg::CNT_W-1:0]  tally_value,
    output logic [spt_pkg::SIZE_W-1:0] entry_size,
    output logic                       entry_store
);
    import spt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [NUM_POINTS-1:0] slot_valid_reg, slot_valid_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // captured item
    logic              cmd_reg;
    logic [PT_W-1:0]   id_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SIZE_W-1:0] wbytes_reg;
    logic              st_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic              hit_reg;

    // classification result
    logic [CLS_W-1:0]  cls_reg;
    logic              back_reg;

    // response payload
    logic              ev_reg, ev_next;
    logic              fa_reg, fa_next;
    logic [CLS_W-1:0]  sc_reg, sc_next;
    logic              wb_reg, wb_next;
    logic [CNT_W-1:0]  tv_reg, tv_next;
    logic [SIZE_W-1:0] es_reg, es_next;
    logic              est_reg, est_next;

    logic              accept;
    logic              done;
    logic              track;
    logic              create;
    logic [PT_W-1:0]   in_slot;
    meta_t             meta_rd, meta_wr;
    counter_row_t      row_rd, row_upd, row_wr;
    class_t            cls_out;

    assign in_slot   = PT_W'(point_id);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_WRITE) && (!rsp_valid_reg || !rsp_stall);
    assign track     = (cmd_reg == CMD_TRACK);
    assign create    = track && !hit_reg;

    spt_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_POINTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (done && track),
        .waddr (id_reg),
        .wdata (meta_wr),
        .re    (accept),
        .raddr (in_slot),
        .rdata (meta_rd)
    );

    spt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_POINTS)
    ) u_count_ram (
        .clk   (clk),
        .we    (done && track),
        .waddr (id_reg),
        .wdata (row_wr),
        .re    (accept),
        .raddr (in_slot),
        .rdata (row_rd)
    );

    spt_classify u_classify (
        .old_addr  (meta_rd.addr),
        .next_addr (addr_reg),
        .size      (meta_rd.bytes),
        .result    (cls_out)
    );

    // Bump the class counter, the total and, on a backward step, the backward counter in one pass.
    always_comb
    begin
        for (int i = 0; i < NUM_CNT; i++)
        begin
            row_upd[i] = row_rd[i]
                + CNT_W'(CLS_W'(i) == cls_reg)
                + CNT_W'((i == CNT_BACK) && back_reg)
                + CNT_W'(i == CNT_TOTAL);
        end
        row_wr = create ? '0 : row_upd;
    end

    always_comb
    begin
        meta_wr.addr  = addr_reg;
        meta_wr.bytes = create ? wbytes_reg : meta_rd.bytes;
        meta_wr.store = create ? st_reg : meta_rd.store;
    end

    // Result fields for the item in the write step.
    always_comb
    begin
        ev_next  = hit_reg;
        fa_next  = create;
        sc_next  = (track && hit_reg) ? cls_reg : CLS_NONE;
        wb_next  = track && hit_reg && back_reg;
        tv_next  = '0;
        es_next  = '0;
        est_next = 1'b0;
        if (track)
        begin
            es_next  = create ? wbytes_reg : meta_rd.bytes;
            est_next = create ? st_reg : meta_rd.store;
            if (hit_reg)
            begin
                tv_next = row_upd[CNT_TOTAL];
            end
        end
        else if (hit_reg)
        begin
            es_next  = meta_rd.bytes;
            est_next = meta_rd.store;
            if (sel_reg < SEL_W'(NUM_CNT))
            begin
                tv_next = row_rd[sel_reg[CNT_IW-1:0]];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Hold here until the result register is free.
                if (done)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    if (create)
                    begin
                        slot_valid_next[id_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            id_reg     <= in_slot;
            addr_reg   <= address;
            wbytes_reg <= word_bytes;
            st_reg     <= store_flag;
            sel_reg    <= tally_select;
            hit_reg    <= slot_valid_reg[in_slot];
        end
        if (state_reg == ST_CALC)
        begin
            cls_reg  <= cls_out.cls;
            back_reg <= cls_out.back;
        end
        if (done)
        begin
            ev_reg  <= ev_next;
            fa_reg  <= fa_next;
            sc_reg  <= sc_next;
            wb_reg  <= wb_next;
            tv_reg  <= tv_next;
            es_reg  <= es_next;
            est_reg <= est_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign entry_valid   = ev_reg;
    assign first_access  = fa_reg;
    assign stride_class  = sc_reg;
    assign went_backward = wb_reg;
    assign tally_value   = tv_reg;
    assign entry_size    = es_reg;
    assign entry_store   = est_reg;

endmodule

/* rtl/core/spt_checker.sv */
// Port-level assertions for stride_pattern_tally and the bind that
// attaches them. Depends on spt_pkg and the top level.
module spt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input logic                       entry_valid,
    input logic                       first_access,
    input logic [spt_pkg::CLS_W-1:0]  stride_class,
    input logic                       went_backward,
    input logic [spt_pkg::CNT_W-1:0]  tally_value
);
    import spt_pkg::*;

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // Creating a slot counts nothing.
    a_create: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && first_access |->
            !entry_valid && stride_class == CLS_NONE && !went_backward
            && tally_value == '0)
        else $error("slot creation reported a stride");

    // An unseen slot yields no count.
    a_unseen: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !entry_valid |-> tally_value == '0 && stride_class == CLS_NONE)
        else $error("count reported for an invalid slot");

    // A backward step is a counted nonzero stride with a nonzero total.
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && went_backward |->
            entry_valid && !first_access && stride_class != CLS_ZERO
            && stride_class != CLS_NONE && tally_value != '0)
        else $error("backward flag on a non-stride result");

endmodule

bind stride_pattern_tally spt_checker u_spt_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the stride pattern tally block.
// Holds a scoreboard class with its own slot table and the top module.
// Depends on spt_pkg and stride_pattern_tally from rtl/core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spt_pkg::*;

    // Tally select codes beyond the stride classes; the counter row order
    // matches the select order, so these double as row indexes.
    localparam logic [SEL_W-1:0] SEL_ZERO    = SEL_W'(MAX_LOG2_STRIDE + 1);
    localparam logic [SEL_W-1:0] SEL_OTHER   = SEL_W'(MAX_LOG2_STRIDE + 2);
    localparam logic [SEL_W-1:0] SEL_BACK    = SEL_W'(CNT_BACK);
    localparam logic [SEL_W-1:0] SEL_TOTAL   = SEL_W'(CNT_TOTAL);
    localparam logic [SEL_W-1:0] SEL_UNUSED  = SEL_W'(CNT_TOTAL + 1);
    localparam logic [SEL_W-1:0] SEL_TOP     = {SEL_W{1'b1}};
    localparam int               LAST_POINT  = NUM_POINTS - 1;
    localparam logic [ADDR_W-1:0] ADDR_ONES  = {ADDR_W{1'b1}};

    localparam int RANDOM_ITEMS  = 1625;
    localparam int STALL_PERCENT = 29;
    localparam int HANG_LIMIT    = 400;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic              entry_valid;
        logic              first_access;
        logic [CLS_W-1:0]  stride_class;
        logic              went_backward;
        logic [CNT_W-1:0]  tally_value;
        logic [SIZE_W-1:0] entry_size;
        logic              entry_store;
    } tally_result_t;

    // Shadow slot table plus the queue of results still owed by the block.
    class stride_scoreboard;
        bit                slot_live [NUM_POINTS];
        logic [ADDR_W-1:0] last_addr [NUM_POINTS];
        logic [SIZE_W-1:0] size_of   [NUM_POINTS];
        logic              store_of  [NUM_POINTS];
        logic [CNT_W-1:0]  tallies   [NUM_POINTS][NUM_CNT];
        tally_result_t     owed_q[$];
        int errors, n_track, n_read, n_created, n_checked;
        int n_zero, n_pow2, n_other, n_back;

        function new();
            for (int p = 0; p < NUM_POINTS; p++) begin
                slot_live[p] = 1'b0;
                last_addr[p] = '0;
                size_of[p]   = '0;
                store_of[p]  = 1'b0;
                for (int c = 0; c < NUM_CNT; c++)
                    tallies[p][c] = '0;
            end
            errors = 0; n_track = 0; n_read = 0; n_created = 0; n_checked = 0;
            n_zero = 0; n_pow2 = 0; n_other = 0; n_back = 0;
        endfunction

        // Class the distance: zero, exactly (size << k) bytes, or other.
        function logic [CLS_W-1:0] class_of(logic [ADDR_W-1:0] prev,
                                            logic [ADDR_W-1:0] next,
                                            logic [SIZE_W-1:0] size);
            logic [ADDR_W-1:0] gap;
            logic [ADDR_W-1:0] span;
            if (next == prev)
                return CLS_ZERO;
            gap = (next > prev) ? next - prev : prev - next;
            if (size == '0)
                return CLS_OTHER;
            for (int k = 0; k <= MAX_LOG2_STRIDE; k++) begin
                span = ADDR_W'(size) << k;
                if (gap == span)
                    return CLS_W'(k);
            end
            return CLS_OTHER;
        endfunction

        // Apply one accepted item to the shadow table and queue its result.
        function void note_item(logic op, logic [ID_W-1:0] id, logic [ADDR_W-1:0] addr,
                                logic [SIZE_W-1:0] wb, logic st, logic [SEL_W-1:0] sel);
            tally_result_t r;
            int            p;
            logic [CLS_W-1:0] c;
            r = '0;
            r.stride_class = CLS_NONE;
            p = int'(id);
            if (p < NUM_POINTS) begin
                r.entry_valid = slot_live[p];
                if (op == CMD_TRACK) begin
                    n_track++;
                    if (!slot_live[p]) begin
                        slot_live[p] = 1'b1;
                        last_addr[p] = addr;
                        size_of[p]   = wb;
                        store_of[p]  = st;
                        for (int i = 0; i < NUM_CNT; i++)
                            tallies[p][i] = '0;
                        r.first_access = 1'b1;
                        n_created++;
                    end else begin
                        c = class_of(last_addr[p], addr, size_of[p]);
                        tallies[p][c]++;
                        tallies[p][CNT_TOTAL]++;
                        if (addr < last_addr[p]) begin
                            tallies[p][CNT_BACK]++;
                            r.went_backward = 1'b1;
                            n_back++;
                        end
                        if (c == CLS_ZERO) n_zero++;
                        else if (c == CLS_OTHER) n_other++;
                        else n_pow2++;
                        last_addr[p]   = addr;
                        r.stride_class = c;
                        r.tally_value  = tallies[p][CNT_TOTAL];
                    end
                end else begin
                    n_read++;
                    if (slot_live[p] && int'(sel) < NUM_CNT)
                        r.tally_value = tallies[p][sel];
                end
                if (slot_live[p]) begin
                    r.entry_size  = size_of[p];
                    r.entry_store = store_of[p];
                end
            end
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // Match one accepted result against the oldest owed one.
        function void check_result(tally_result_t got);
            tally_result_t want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
                return;
            end
            want = owed_q.pop_front();
            n_checked++;
            compare_field("entry_valid",   CNT_W'(want.entry_valid),
                          CNT_W'(got.entry_valid));
            compare_field("first_access",  CNT_W'(want.first_access),
                          CNT_W'(got.first_access));
            compare_field("stride_class",  CNT_W'(want.stride_class),
                          CNT_W'(got.stride_class));
            compare_field("went_backward", CNT_W'(want.went_backward),
                          CNT_W'(got.went_backward));
            compare_field("tally_value",   want.tally_value,   got.tally_value);
            compare_field("entry_size",    CNT_W'(want.entry_size),
                          CNT_W'(got.entry_size));
            compare_field("entry_store",   CNT_W'(want.entry_store),
                          CNT_W'(got.entry_store));
        endfunction

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic              cmd;
    logic [ID_W-1:0]   point_id;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] word_bytes;
    logic              store_flag;
    logic [SEL_W-1:0]  tally_select;
    logic              rsp_valid;
    logic              rsp_stall;
    logic              entry_valid;
    logic              first_access;
    logic [CLS_W-1:0]  stride_class;
    logic              went_backward;
    logic [CNT_W-1:0]  tally_value;
    logic [SIZE_W-1:0] entry_size;
    logic              entry_store;

    stride_scoreboard sb;
    bit               calm;       // high while neither side may idle
    int               hang_count;

    stride_pattern_tally u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .point_id      (point_id),
        .address       (address),
        .word_bytes    (word_bytes),
        .store_flag    (store_flag),
        .tally_select  (tally_select),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .entry_valid   (entry_valid),
        .first_access  (first_access),
        .stride_class  (stride_class),
        .went_backward (went_backward),
        .tally_value   (tally_value),
        .entry_size    (entry_size),
        .entry_store   (entry_store)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive every input to a known value before the first edge.
    initial
    begin
        sb           = new();
        calm         = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        cmd          = CMD_TRACK;
        point_id     = '0;
        address      = '0;
        word_bytes   = '0;
        store_flag   = 1'b0;
        tally_select = '0;
        rsp_stall    = 1'b0;
    end

    // Response side: stall at random about 29 percent of the time, never while calm.
    always @(negedge clk)
    begin
        rsp_stall <= !calm && ($urandom_range(0, 99) < STALL_PERCENT);
    end

    // Sample results at the rising edge; the block's outputs still hold
    // their pre-edge values here since it updates them with nonblocking writes.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result({entry_valid, first_access, stride_class, went_backward,
                             tally_value, entry_size, entry_store});
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial hang_count = 0;

    // Present one item at a falling edge, hold it until the block takes it,
    // then note it in the scoreboard. Called and returns at a falling edge.
    task automatic send_item(input logic op, input int id, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] wb, input logic st,
                             input logic [SEL_W-1:0] sel);
        // Unless calm, drop valid for a random gap first; each idle cycle gets one write.
        if (!calm) begin
            while ($urandom_range(0, 99) < STALL_PERCENT) begin
                req_valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_valid    <= 1'b1;
        cmd          <= op;
        point_id     <= ID_W'(id);
        address      <= addr;
        word_bytes   <= wb;
        store_flag   <= st;
        tally_select <= sel;
        // Hold the payload until an edge where the block does not stall.
        do
            @(posedge clk);
        while (req_stall);
        sb.note_item(op, ID_W'(id), addr, wb, st, sel);
        @(negedge clk);
    endtask

    // Pick the next address of a slot: mostly strides that land in one of
    // the classes, with some wide power-of-two jumps, odd offsets and
    // wholly random addresses mixed in.
    function automatic logic [ADDR_W-1:0] next_address(int id);
        logic [ADDR_W-1:0] prev;
        logic [ADDR_W-1:0] span;
        int                pick;
        int                k;
        pick = $urandom_range(0, 99);
        if (!sb.slot_live[id] || pick >= 88)
            return {$urandom, $urandom};
        prev = sb.last_addr[id];
        if (pick < 10)
            return prev;
        if (pick < 65)
            k = $urandom_range(0, MAX_LOG2_STRIDE);
        else if (pick < 75)
            k = $urandom_range(MAX_LOG2_STRIDE + 1, MAX_LOG2_STRIDE + 3);
        else
            k = -1;
        if (k >= 0)
            span = ADDR_W'(sb.size_of[id]) << k;
        else
            span = ADDR_W'($urandom_range(1, 2000));
        return $urandom_range(0, 1) ? prev + span : prev - span;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return {SIZE_W{1'b1}};
        return SIZE_W'($urandom_range(1, 255));
    endfunction

    initial
    begin
        int               id;
        int               prev_id;
        logic             op;
        logic [SEL_W-1:0] sel;

        // Hold reset, then release it at a falling edge.
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reads of slots never seen.
        send_item(CMD_READ, 0, '0, 8'd1, 1'b0, SEL_TOTAL);
        send_item(CMD_READ, LAST_POINT, ADDR_ONES, 8'd1, 1'b1, SEL_TOP);
        // Create slot 0 with 8-byte words, then walk zero, 1 word, 64 words,
        // a 128-word jump (too wide, so other), 2 words back, an odd offset.
        // The second item's size and flag differ and must be ignored.
        send_item(CMD_TRACK, 0, 64'd0, 8'd8, 1'b1, '0);
        send_item(CMD_TRACK, 0, 64'd0, 8'd4, 1'b0, '0);
        send_item(CMD_TRACK, 0, 64'd8, 8'd8, 1'b1, '0);
        send_item(CMD_TRACK, 0, 64'd520, 8'd8, 1'b1, '0);
        send_item(CMD_TRACK, 0, 64'd1544, 8'd8, 1'b1, '0);
        send_item(CMD_TRACK, 0, 64'd1528, 8'd8, 1'b1, '0);
        send_item(CMD_TRACK, 0, 64'd1531, 8'd8, 1'b1, '0);
        // Top slot at the address and size extremes, then a full-range drop, one word and 64 words.
        send_item(CMD_TRACK, LAST_POINT, ADDR_ONES, 8'd255, 1'b0, SEL_TOP);
        send_item(CMD_TRACK, LAST_POINT, 64'd0, 8'd1, 1'b1, '0);
        send_item(CMD_TRACK, LAST_POINT, 64'd255, 8'd255, 1'b0, '0);
        send_item(CMD_TRACK, LAST_POINT, 64'd16575, 8'd255, 1'b0, '0);
        // Slot with a stored size of zero: any nonzero distance is other.
        send_item(CMD_TRACK, 5, 64'd100, 8'd0, 1'b1, '0);
        send_item(CMD_TRACK, 5, 64'd100, 8'd0, 1'b1, '0);
        send_item(CMD_TRACK, 5, 64'd101, 8'd0, 1'b1, '0);
        // Read back slot 0 counters, including an unused select, then one top-slot counter.
        send_item(CMD_READ, 0, '0, 8'd0, 1'b0, 4'd0);
        send_item(CMD_READ, 0, '0, 8'd0, 1'b0, 4'd1);
        send_item(CMD_READ, 0, '0, 8'd0, 1'b0, SEL_W'(MAX_LOG2_STRIDE));
        send_item(CMD_READ, 0, '0, 8'd0, 1'b0, SEL_ZERO);
        send_item(CMD_READ, 0, '0, 8'd0, 1'b0, SEL_OTHER);
        send_item(CMD_READ, 0, '0, 8'd0, 1'b0, SEL_BACK);
        send_item(CMD_READ, 0, '0, 8'd0, 1'b0, SEL_TOTAL);
        send_item(CMD_READ, 0, '0, 8'd0, 1'b0, SEL_UNUSED);
        send_item(CMD_READ, LAST_POINT, '0, 8'd0, 1'b0, SEL_OTHER);

        // Random: mostly stride walks per slot, with frequent back-to-back
        // hits on the same slot to stress the read-modify-write path.
        prev_id = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 700 && n < 1000);
            if ($urandom_range(0, 99) < 40)
                id = prev_id;
            else
                id = $urandom_range(0, NUM_POINTS - 1);
            prev_id = id;
            op = ($urandom_range(0, 99) < 25) ? CMD_READ : CMD_TRACK;
            if ($urandom_range(0, 99) < 85)
                sel = SEL_W'($urandom_range(0, CNT_TOTAL));
            else
                sel = SEL_W'($urandom_range(CNT_TOTAL + 1, (1 << SEL_W) - 1));
            if (op == CMD_TRACK)
                send_item(op, id, next_address(id), pick_size(),
                          1'($urandom_range(0, 1)), sel);
            else
                send_item(op, id, {$urandom, $urandom}, pick_size(),
                          1'($urandom_range(0, 1)), sel);
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        // Drain: wait for every owed result, then a few more cycles so a
        // stray extra result would still be caught.
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d track and %0d read items on %0d created slots, %0d results",
                 sb.n_track, sb.n_read, sb.n_created, sb.n_checked);
        $display("Strides seen: %0d zero, %0d power-of-two words, %0d other, %0d backward",
                 sb.n_zero, sb.n_pow2, sb.n_other, sb.n_back);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
